// ===== src/amtf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amtf_pkg
// shared types and line-pattern constants of the aux manchester tx framer
// ----------------------------------------------------------------------------
package amtf_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] code_word;
		logic        frame_end;
	} word_item_t;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_DATA,
		OP_FULL_END,
		OP_ODD_END
	} op_t;

	typedef struct packed {
		logic        hdr;
		op_t         op;
		logic [31:0] word;
	} cmd_t;

	localparam logic [31:0] HDR_WORD_A = 32'hAAAAAAAA;
	localparam logic [31:0] HDR_WORD_B = 32'h0FAAAAAA;
	localparam logic [31:0] PAD_WORD   = 32'hFFFFFFFF;
	localparam logic [31:0] STOP_FULL  = 32'hFFFFFF0F;
	localparam logic [15:0] STOP_HIGH  = 16'hFF0F;
	localparam logic [1:0]  SYM_ONE    = 2'h1;
	localparam logic [1:0]  SYM_ZERO   = 2'h2;

endpackage

// ===== src/amtf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amtf_front
// accepts frame bytes, encodes them and issues one command per needed burst
// ----------------------------------------------------------------------------
module amtf_front import amtf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_data,
	input  logic       cmd_full,
	output logic       cmd_push,
	output cmd_t       cmd_data
);

	logic [15:0] pending_code_q;
	logic        have_pending_q;
	logic        in_frame_q;
	logic        accept;
	logic [15:0] code;
	op_t         op;

	function automatic logic [15:0] encode_byte(input logic [7:0] b);
		logic [15:0] c;
		c = '0;
		for (int k = 0; k < 8; k++) begin
			c[2*k +: 2] = b[7-k] ? SYM_ONE : SYM_ZERO;
		end
		return c;
	endfunction

	assign byte_stall = cmd_full;
	assign accept     = byte_valid && !byte_stall;
	assign code       = encode_byte(byte_data.data_byte);

	always_comb begin
		if (!have_pending_q) begin
			op = byte_data.last_byte ? OP_ODD_END : OP_NONE;
		end else begin
			op = byte_data.last_byte ? OP_FULL_END : OP_DATA;
		end
	end

	assign cmd_data.hdr  = !in_frame_q;
	assign cmd_data.op   = op;
	assign cmd_data.word = have_pending_q ? {code, pending_code_q} : {STOP_HIGH, code};
	assign cmd_push      = accept && (!in_frame_q || op != OP_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_code_q <= '0;
			have_pending_q <= 1'b0;
			in_frame_q     <= 1'b0;
		end else if (accept) begin
			if (byte_data.last_byte) begin
				pending_code_q <= '0;
				have_pending_q <= 1'b0;
				in_frame_q     <= 1'b0;
			end else if (!have_pending_q) begin
				pending_code_q <= code;
				have_pending_q <= 1'b1;
				in_frame_q     <= 1'b1;
			end else begin
				pending_code_q <= '0;
				have_pending_q <= 1'b0;
				in_frame_q     <= 1'b1;
			end
		end
	end

endmodule

// ===== src/amtf_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amtf_fifo
// small register queue that decouples the front and back parts
// ----------------------------------------------------------------------------
module amtf_fifo #(
	parameter int WIDTH = 35,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_FULL);
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");

endmodule

// ===== src/amtf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// amtf_back
// expands queued commands into header, data, stop and pad words
// ----------------------------------------------------------------------------
module amtf_back import amtf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       cmd_data,
	input  logic       cmd_empty,
	output logic       cmd_pop,
	output logic       word_valid,
	input  logic       word_stall,
	output word_item_t word_data
);

	logic [2:0]  t_q;
	logic        busy_q;
	logic        word_valid_q;
	word_item_t  word_q;
	logic [2:0]  t_cur;
	logic [2:0]  t_last;
	logic        load;
	word_item_t  next_word;

	assign t_cur = busy_q ? t_q : (cmd_data.hdr ? 3'd0 : 3'd2);

	always_comb begin
		case (cmd_data.op)
			OP_NONE: t_last = 3'd1;
			OP_DATA: t_last = 3'd2;
			default: t_last = 3'd4;
		endcase
	end

	always_comb begin
		next_word.frame_end = 1'b0;
		case (t_cur)
			3'd0:    next_word.code_word = HDR_WORD_A;
			3'd1:    next_word.code_word = HDR_WORD_B;
			3'd2:    next_word.code_word = cmd_data.word;
			3'd3:    next_word.code_word = (cmd_data.op == OP_FULL_END) ? STOP_FULL : PAD_WORD;
			default: begin
				next_word.code_word = PAD_WORD;
				next_word.frame_end = 1'b1;
			end
		endcase
	end

	assign load       = (!word_valid_q || !word_stall) && !cmd_empty;
	assign cmd_pop    = load && (t_cur == t_last);
	assign word_valid = word_valid_q;
	assign word_data  = word_q;

	always_ff @(posedge clk) begin
		if (load) begin
			word_q <= next_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q          <= '0;
			busy_q       <= 1'b0;
			word_valid_q <= 1'b0;
		end else begin
			if (!word_valid_q || !word_stall) begin
				word_valid_q <= !cmd_empty;
			end
			if (load) begin
				if (t_cur == t_last) begin
					busy_q <= 1'b0;
				end else begin
					busy_q <= 1'b1;
					t_q    <= t_cur + 3'd1;
				end
			end
		end
	end

	a_end_is_pad: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid && word_data.frame_end |-> word_data.code_word == PAD_WORD)
		else $error("frame end on a non pad word");
	a_end_pops: assert property (@(posedge clk) disable iff (!arst_n)
		load && next_word.frame_end |-> cmd_pop)
		else $error("frame end word without retiring its command");

endmodule

// ===== src/aux_manchester_tx_framer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aux_manchester_tx_framer_unit
// manchester-ii transmit framer: bytes in, 32-bit line-pattern words out
//
// channel   signals                            payload
// byte      byte_valid / byte_stall / byte_data  byte_item_t (data_byte, last_byte)
// word      word_valid / word_stall / word_data  word_item_t (code_word, frame_end)
//
// mid-frame a byte is taken every cycle while the command queue has room
// the back part emits one word per cycle unless stalled or out of commands:
// 1 to 5 words per command, frame starts and frame ends giving the longer counts
// output words sit in a register, so a stalled word does not stop intake
// until the queue of QUEUE_DEPTH commands fills
// reset clears the framing state, the queue and the output valid at once
// ----------------------------------------------------------------------------
module aux_manchester_tx_framer_unit import amtf_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	output logic       byte_stall,
	input  byte_item_t byte_data,
	output logic       word_valid,
	input  logic       word_stall,
	output word_item_t word_data
);

	logic cmd_push;
	logic cmd_pop;
	logic cmd_full;
	logic cmd_empty;
	cmd_t cmd_in;
	cmd_t cmd_out;

	amtf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.cmd_full   (cmd_full),
		.cmd_push   (cmd_push),
		.cmd_data   (cmd_in)
	);

	amtf_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.pop       (cmd_pop),
		.pop_data  (cmd_out),
		.full      (cmd_full),
		.empty     (cmd_empty)
	);

	amtf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_data   (cmd_out),
		.cmd_empty  (cmd_empty),
		.cmd_pop    (cmd_pop),
		.word_valid (word_valid),
		.word_stall (word_stall),
		.word_data  (word_data)
	);

endmodule
